>>> hw/rtl/ipid_pkg.sv
// Package for the incremental PID controller: field widths, default
// parameter values and configuration register indexes.
// No dependencies.
`default_nettype none

package ipid_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int GAIN_FRAC_DEF  = 8;

    localparam int GAIN_W = 16;
    localparam int LIM_W  = 15;
    localparam int ACC_W  = 16;
    localparam int APB_DW = 32;
    localparam int APB_AW = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_GAIN_PROP    = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_INTEG   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_DERIV   = 3'd2;
    localparam logic [IDX_W-1:0] REG_MOTOR_LIMIT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

    localparam logic [LIM_W-1:0] LIM_RESET = 15'h7fff;

endpackage

`default_nettype wire

>>> hw/rtl/incremental_pid_clamped.sv
// Top level of the incremental PID controller: stream ports, APB register
// file, error history and clamped output accumulator.
// Depends on ipid_pkg and ipid_term.
`default_nettype none

// Incremental (velocity-form) PID. Each error word on the slave stream yields
// one drive word on the master stream. Throughput is one word per clock while
// the master side does not stall: the three gain multiplies, the clamps and
// the accumulator update sit in one registered stage around the accumulator
// loop. in_err_reg holds each accepted error word, acc_reg its result. A word
// can be accepted while the previous result waits on the master side. Gains
// are unsigned Q8.8; every term and the output saturate, nothing wraps.
// Registers (APB, 4-byte stride): 0 gain_prop, 1 gain_integ, 2 gain_deriv,
// 3 motor_limit, 4 output_limit. Write registers only while the block is idle.
module incremental_pid_clamped #(
    parameter int DATA_WIDTH     = ipid_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ipid_pkg::GAIN_FRAC_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // [DATA_WIDTH-1:0] error_sample, zero padding above
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]        s_tdata,

    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // [DATA_WIDTH-1:0] drive_value, zero padding above
    output logic [((DATA_WIDTH+7)/8)*8-1:0]             m_tdata,

    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [ipid_pkg::APB_AW-1:0]            paddr,
    input  wire logic [ipid_pkg::APB_DW-1:0]            pwdata,
    output logic [ipid_pkg::APB_DW-1:0]                 prdata,
    output logic                                        pready
);

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int D1_W    = DATA_WIDTH + 1;
    localparam int D2_W    = DATA_WIDTH + 2;
    localparam int TERM_W  = ipid_pkg::LIM_W + 1;
    localparam int SUM_W   = ipid_pkg::ACC_W + 2;

    // configuration
    logic [ipid_pkg::GAIN_W-1:0] gain_prop_reg;
    logic [ipid_pkg::GAIN_W-1:0] gain_integ_reg;
    logic [ipid_pkg::GAIN_W-1:0] gain_deriv_reg;
    logic [ipid_pkg::LIM_W-1:0]  motor_limit_reg;
    logic [ipid_pkg::LIM_W-1:0]  output_limit_reg;
    logic                        cfg_wr;
    logic [ipid_pkg::IDX_W-1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ipid_pkg::APB_AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg    <= '0;
            gain_integ_reg   <= '0;
            gain_deriv_reg   <= '0;
            motor_limit_reg  <= ipid_pkg::LIM_RESET;
            output_limit_reg <= ipid_pkg::LIM_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                ipid_pkg::REG_GAIN_PROP:    gain_prop_reg    <= pwdata[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::REG_GAIN_INTEG:   gain_integ_reg   <= pwdata[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::REG_GAIN_DERIV:   gain_deriv_reg   <= pwdata[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::REG_MOTOR_LIMIT:  motor_limit_reg  <= pwdata[ipid_pkg::LIM_W-1:0];
                ipid_pkg::REG_OUTPUT_LIMIT: output_limit_reg <= pwdata[ipid_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            ipid_pkg::REG_GAIN_PROP:    prdata = ipid_pkg::APB_DW'(gain_prop_reg);
            ipid_pkg::REG_GAIN_INTEG:   prdata = ipid_pkg::APB_DW'(gain_integ_reg);
            ipid_pkg::REG_GAIN_DERIV:   prdata = ipid_pkg::APB_DW'(gain_deriv_reg);
            ipid_pkg::REG_MOTOR_LIMIT:  prdata = ipid_pkg::APB_DW'(motor_limit_reg);
            ipid_pkg::REG_OUTPUT_LIMIT: prdata = ipid_pkg::APB_DW'(output_limit_reg);
            default:                    prdata = '0;
        endcase
    end

    // pipeline control
    logic                          in_valid_reg;
    logic signed [DATA_WIDTH-1:0]  in_err_reg;
    logic                          out_valid_reg;
    logic                          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_err_reg <= $signed(s_tdata[DATA_WIDTH-1:0]);
        end
    end

    // controller state
    logic signed [DATA_WIDTH-1:0]    prev_err_reg;
    logic signed [DATA_WIDTH-1:0]    prev_prev_err_reg;
    logic signed [ipid_pkg::ACC_W-1:0] acc_reg;
    logic signed [ipid_pkg::ACC_W-1:0] acc_next;

    logic signed [D1_W-1:0]   diff1;
    logic signed [D2_W-1:0]   diff2;
    logic signed [D2_W-1:0]   e_x2;
    logic signed [D2_W-1:0]   p_x2;
    logic signed [D2_W-1:0]   pp_x2;
    logic signed [TERM_W-1:0] term_p;
    logic signed [TERM_W-1:0] term_i;
    logic signed [TERM_W-1:0] term_d;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  motor_hi;
    logic signed [SUM_W-1:0]  output_hi;
    logic signed [SUM_W-1:0]  clamp1;
    logic signed [SUM_W-1:0]  clamp2;

    assign diff1 = D1_W'(in_err_reg) - D1_W'(prev_err_reg);
    assign e_x2  = D2_W'(in_err_reg);
    assign p_x2  = D2_W'(prev_err_reg);
    assign pp_x2 = D2_W'(prev_prev_err_reg);
    assign diff2 = e_x2 - (p_x2 <<< 1) + pp_x2;

    ipid_term #(.DIFF_W(D1_W), .FRAC_BITS(GAIN_FRAC_BITS)) u_term_p (
        .diff (diff1),
        .gain (gain_prop_reg),
        .lim  (motor_limit_reg),
        .term (term_p)
    );

    ipid_term #(.DIFF_W(DATA_WIDTH), .FRAC_BITS(GAIN_FRAC_BITS)) u_term_i (
        .diff (in_err_reg),
        .gain (gain_integ_reg),
        .lim  (motor_limit_reg),
        .term (term_i)
    );

    ipid_term #(.DIFF_W(D2_W), .FRAC_BITS(GAIN_FRAC_BITS)) u_term_d (
        .diff (diff2),
        .gain (gain_deriv_reg),
        .lim  (motor_limit_reg),
        .term (term_d)
    );

    assign sum = SUM_W'(acc_reg) + SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d);
    assign motor_hi  = $signed(SUM_W'(motor_limit_reg));
    assign output_hi = $signed(SUM_W'(output_limit_reg));

    always_comb
    begin
        if (sum > motor_hi)
        begin
            clamp1 = motor_hi;
        end
        else if (sum < -motor_hi)
        begin
            clamp1 = -motor_hi;
        end
        else
        begin
            clamp1 = sum;
        end

        if (clamp1 > output_hi)
        begin
            clamp2 = output_hi;
        end
        else if (clamp1 < -output_hi)
        begin
            clamp2 = -output_hi;
        end
        else
        begin
            clamp2 = clamp1;
        end

        acc_next = clamp2[ipid_pkg::ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg      <= '0;
            prev_prev_err_reg <= '0;
            acc_reg           <= '0;
        end
        else if (advance)
        begin
            prev_err_reg      <= in_err_reg;
            prev_prev_err_reg <= prev_err_reg;
            acc_reg           <= acc_next;
        end
    end

    // result word: the accumulator holds the latest result
    logic signed [DATA_WIDTH+ipid_pkg::ACC_W-1:0] acc_wide;

    assign acc_wide = (DATA_WIDTH + ipid_pkg::ACC_W)'(acc_reg);
    assign m_tdata  = TDATA_W'(acc_wide[DATA_WIDTH-1:0]);

`ifndef SYNTH
    logic signed [ipid_pkg::LIM_W+1:0] acc_chk;
    logic signed [ipid_pkg::LIM_W+1:0] motor_chk;

    assign acc_chk   = (ipid_pkg::LIM_W + 2)'(acc_reg);
    assign motor_chk = $signed((ipid_pkg::LIM_W + 2)'(motor_limit_reg));

    a_acc_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (acc_chk <= motor_chk) && (acc_chk >= -motor_chk))
        else $error("accumulator outside motor limit");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(in_err_reg))
        else $error("stalled input word overwritten");

    a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (prev_err_reg == $past(in_err_reg))
                    && (prev_prev_err_reg == $past(prev_err_reg)))
        else $error("error history not shifted");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/ipid_term.sv
// One gain term: magnitude times unsigned fixed-point gain, truncated
// toward zero and clamped to a symmetric limit. Depends on ipid_pkg.
`default_nettype none

module ipid_term #(
    parameter int DIFF_W    = 17,
    parameter int FRAC_BITS = ipid_pkg::GAIN_FRAC_DEF
) (
    input  wire logic signed [DIFF_W-1:0]              diff,
    input  wire logic        [ipid_pkg::GAIN_W-1:0]    gain,
    input  wire logic        [ipid_pkg::LIM_W-1:0]     lim,
    output logic signed      [ipid_pkg::LIM_W:0]       term
);

    localparam int PROD_W = DIFF_W + ipid_pkg::GAIN_W;

    logic                          neg;
    logic [DIFF_W-1:0]             mag;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W-1:0]             shifted;
    logic [PROD_W-1:0]             lim_ext;
    logic [ipid_pkg::LIM_W-1:0]    mag_sat;
    logic signed [ipid_pkg::LIM_W:0] pos_term;

    assign neg      = diff[DIFF_W-1];
    assign mag      = neg ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign prod     = PROD_W'(mag) * PROD_W'(gain);
    assign shifted  = prod >> FRAC_BITS;
    assign lim_ext  = PROD_W'(lim);
    assign mag_sat  = (shifted > lim_ext) ? lim : shifted[ipid_pkg::LIM_W-1:0];
    assign pos_term = $signed({1'b0, mag_sat});
    assign term     = neg ? -pos_term : pos_term;

endmodule

`default_nettype wire

>>> sim/incremental_pid_clamped_test.sv
// Self-checking testbench for incremental_pid_clamped: drives error words over the
// input stream and APB register writes, predicts every drive word and compares it.
// Depends on ipid_pkg and the incremental_pid_clamped RTL.
`timescale 1ns / 1ps

module incremental_pid_clamped_test;

    localparam int DW              = ipid_pkg::DATA_WIDTH_DEF;
    localparam int FRAC            = ipid_pkg::GAIN_FRAC_DEF;
    localparam int TDW             = ((DW + 7) / 8) * 8;
    localparam int QUIET_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_BLOCKS   = 9;
    localparam int BLOCK_ITEMS     = 100;
    localparam int PLAN_ROWS       = 30;

    localparam logic [ipid_pkg::IDX_W-1:0] REG_UNUSED = 3'd5;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [ipid_pkg::IDX_W-1:0]  reg_idx;
        logic [31:0]                 value;
        logic                        pinned;
        logic [15:0]                 drive;
    } plan_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // [15:0] error_sample
    logic [TDW-1:0]                s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // [15:0] drive_value
    logic [TDW-1:0]                m_tdata;

    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [ipid_pkg::APB_AW-1:0]   paddr   = '0;
    logic [ipid_pkg::APB_DW-1:0]   pwdata  = '0;
    logic [ipid_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    logic                          pin_valid = 1'b0;
    logic [DW-1:0]                 pin_drive = '0;

    logic [15:0] gain_p    = '0;
    logic [15:0] gain_i    = '0;
    logic [15:0] gain_d    = '0;
    logic [14:0] lim_motor = ipid_pkg::LIM_RESET;
    logic [14:0] lim_out   = ipid_pkg::LIM_RESET;
    longint      err_prev1   = 0;
    longint      err_prev2   = 0;
    longint      drive_state = 0;

    logic [DW-1:0] drive_expected[$];
    logic [DW-1:0] err_walk     = '0;
    int            fail_count   = 0;
    int            quiet_cycles = 0;
    int            stall_span   = 0;
    int            tx_idle_pct  = 0;
    int            rx_idle_pct  = 0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_SAMPLE, '0, 32'h0000_7FFF, 1'b1, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_8000, 1'b1, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_GAIN_INTEG,   32'h0000_0100, 1'b0, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_GAIN_PROP,    32'hFFFF_0000, 1'b0, 16'h0000},
        '{ROW_WRITE,  REG_UNUSED,                 32'h0000_FFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_7FFF, 1'b1, 16'h7FFF},
        '{ROW_SAMPLE, '0, 32'h0000_8000, 1'b1, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_8000, 1'b1, 16'h8001},
        '{ROW_WRITE,  ipid_pkg::REG_MOTOR_LIMIT,  32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_1234, 1'b1, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_MOTOR_LIMIT,  32'h0000_7FFF, 1'b0, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_OUTPUT_LIMIT, 32'h0000_0064, 1'b0, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_GAIN_INTEG,   32'h0000_0001, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_00FF, 1'b1, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_FF01, 1'b1, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_7FFF, 1'b1, 16'h0064},
        '{ROW_SAMPLE, '0, 32'h0000_8000, 1'b1, 16'hFFE4},
        '{ROW_WRITE,  ipid_pkg::REG_GAIN_PROP,    32'h0000_FFFF, 1'b0, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_GAIN_INTEG,   32'h0000_FFFF, 1'b0, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_GAIN_DERIV,   32'h0000_FFFF, 1'b0, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_MOTOR_LIMIT,  32'h0000_03E8, 1'b0, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_OUTPUT_LIMIT, 32'h0000_7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_0001, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_FFFF, 1'b0, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_MOTOR_LIMIT,  32'h0000_7FFF, 1'b0, 16'h0000},
        '{ROW_WRITE,  ipid_pkg::REG_OUTPUT_LIMIT, 32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 32'h0000_4000, 1'b1, 16'h0000}
    };

    incremental_pid_clamped u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp_mag(longint x, longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    function automatic longint scaled_term(longint diff, logic [15:0] gain, logic [14:0] lim);
        longint mag;
        longint prod;
        mag  = (diff < 0) ? -diff : diff;
        prod = (mag * longint'(gain)) >>> FRAC;
        if (prod > longint'(lim))
            prod = longint'(lim);
        return (diff < 0) ? -prod : prod;
    endfunction

    function automatic logic [DW-1:0] pid_advance(logic [DW-1:0] sample);
        longint e;
        longint acc;
        e   = longint'($signed(sample));
        acc = drive_state
            + scaled_term(e - err_prev1, gain_p, lim_motor)
            + scaled_term(e, gain_i, lim_motor)
            + scaled_term(e - 2 * err_prev1 + err_prev2, gain_d, lim_motor);
        acc = clamp_mag(acc, longint'(lim_motor));
        acc = clamp_mag(acc, longint'(lim_out));
        drive_state = acc;
        err_prev2   = err_prev1;
        err_prev1   = e;
        return acc[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] next_error();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 16'($urandom());
            4, 5:       v = 16'(int'($urandom_range(0, 600)) - 300);
            6:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    3:       v = 16'h0001;
                    default: v = 16'hFFFF;
                endcase
            end
            default:    v = err_walk + 16'(int'($urandom_range(0, 64)) - 32);
        endcase
        err_walk = v;
        return v;
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : word_monitor
        logic [DW-1:0] predicted;
        logic [DW-1:0] want;
        logic          moved;
        moved = 1'b0;
        if (s_tvalid && s_tready)
        begin
            predicted = pid_advance(s_tdata[DW-1:0]);
            drive_expected.push_back(pin_valid ? pin_drive : predicted);
            moved = 1'b1;
        end
        if (m_tvalid && m_tready)
        begin
            moved = 1'b1;
            if (drive_expected.size() == 0)
                flag_error($sformatf("drive word %h with nothing pending", m_tdata[DW-1:0]));
            else
            begin
                want = drive_expected.pop_front();
                if (m_tdata[DW-1:0] !== want)
                    flag_error($sformatf("drive_value expected %h, got %h",
                                         want, m_tdata[DW-1:0]));
            end
        end
        if (moved || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_span > 0)
        begin
            m_tready   <= 1'b0;
            stall_span <= stall_span - 1;
        end
        else
            m_tready <= (int'($urandom_range(0, 99)) >= rx_idle_pct);
    end

    task automatic reg_write(input logic [ipid_pkg::IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ipid_pkg::REG_GAIN_PROP:    gain_p    = value[15:0];
            ipid_pkg::REG_GAIN_INTEG:   gain_i    = value[15:0];
            ipid_pkg::REG_GAIN_DERIV:   gain_d    = value[15:0];
            ipid_pkg::REG_MOTOR_LIMIT:  lim_motor = value[14:0];
            ipid_pkg::REG_OUTPUT_LIMIT: lim_out   = value[14:0];
            default: ;
        endcase
    endtask

    task automatic send_error(input logic [DW-1:0] err, input logic pinned,
                              input logic [DW-1:0] drive);
        while (int'($urandom_range(0, 99)) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= TDW'(err);
        pin_valid <= pinned;
        pin_drive <= drive;
        do @(posedge clk); while (!s_tready);
    endtask

    // drop valid, wait out every pending drive word, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (drive_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_setting(input int kind);
        logic [15:0] gp;
        logic [15:0] gi;
        logic [15:0] gd;
        logic [14:0] ml;
        logic [14:0] ol;
        gp = 16'($urandom_range(0, 767));
        gi = 16'($urandom_range(0, 767));
        gd = 16'($urandom_range(0, 767));
        ml = 15'($urandom_range(0, 32767));
        ol = 15'($urandom_range(0, 32767));
        case (kind)
            1:
            begin
                gp = 16'hFFFF;
                gi = 16'hFFFF;
                gd = 16'hFFFF;
                ml = ipid_pkg::LIM_RESET;
                ol = ipid_pkg::LIM_RESET;
            end
            2:
            begin
                gp = 16'($urandom());
                gi = 16'($urandom());
                gd = 16'($urandom());
                ml = 15'($urandom_range(0, 2000));
            end
            3:
            begin
                if ($urandom_range(0, 1) == 0)
                    ml = '0;
                else
                    ol = '0;
            end
            4:
            begin
                ml = 15'($urandom_range(100, 20000));
                ol = ipid_pkg::LIM_RESET;
            end
            default: ;
        endcase
        reg_write(ipid_pkg::REG_GAIN_PROP,    {16'($urandom()), gp});
        reg_write(ipid_pkg::REG_GAIN_INTEG,   {16'($urandom()), gi});
        reg_write(ipid_pkg::REG_GAIN_DERIV,   {16'($urandom()), gd});
        reg_write(ipid_pkg::REG_MOTOR_LIMIT,  {17'($urandom()), ml});
        reg_write(ipid_pkg::REG_OUTPUT_LIMIT, {17'($urandom()), ol});
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == ROW_WRITE)
            begin
                settle();
                reg_write(plan[r].reg_idx, plan[r].value);
            end
            else
                send_error(plan[r].value[DW-1:0], plan[r].pinned, plan[r].drive);
        end

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            case (blk / 3)
                0:
                begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 72;
                end
                1:
                begin
                    tx_idle_pct = 72;
                    rx_idle_pct = 6;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            settle();
            program_setting(blk % 5);
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                if (blk == 0 && n == 30)
                    stall_span <= HOLD_OFF_CYCLES;
                if (blk == 4 && n == 50)
                    settle();
                send_error(next_error(), 1'b0, '0);
            end
        end

        settle();
        if (drive_expected.size() != 0)
            flag_error($sformatf("%0d drive words never arrived", drive_expected.size()));
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
